// ===== hw/rtl/csfe_pkg.sv =====
package csfe_pkg;

	// Surface and store geometry
	localparam int WIDTH_MAX  = 64;
	localparam int HEIGHT_MAX = 64;
	localparam int PIXEL_BITS = 32;

	localparam int STORE_DEPTH = WIDTH_MAX * HEIGHT_MAX;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COL_W       = $clog2(WIDTH_MAX);
	localparam int ROW_W       = $clog2(HEIGHT_MAX);
	localparam int DIM_W       = $clog2(((WIDTH_MAX > HEIGHT_MAX) ? WIDTH_MAX : HEIGHT_MAX) + 1);
	localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

	// Fixed field widths
	localparam int KIND_W  = 3;
	localparam int COORD_W = 16;
	localparam int WORD_W  = 32;
	localparam int CFG_W   = 7;
	localparam int APB_W   = 32;
	localparam int PADDR_W = 3;

	// Bit of (age + row + column) that selects the ants colour
	localparam int ANTS_BIT = 2;
	localparam int PHASE_W  = ANTS_BIT + 1;

	// Command codes
	localparam logic [KIND_W-1:0] KIND_HLINE_SOLID = 3'd0;
	localparam logic [KIND_W-1:0] KIND_VLINE_SOLID = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RECT_SOLID  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HLINE_ANTS  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_VLINE_ANTS  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SET_PIXEL   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_READ_PIXEL  = 3'd6;

	// Register index, taken from paddr bit 2
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic [PIXEL_BITS-1:0] pixel_t;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} surface_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CLIP,
		ST_BASE,
		ST_LIMIT,
		ST_PIXEL,
		ST_RDWAIT,
		ST_FILL,
		ST_DONE
	} state_t;

	// A zero register acts as one, anything above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] eff_dim(logic [CFG_W-1:0] raw, int unsigned lim);
		logic [DIM_W-1:0] res;
		if (raw == '0) begin
			res = DIM_W'(1);
		end else if (int'(raw) > lim) begin
			res = DIM_W'(lim);
		end else begin
			res = DIM_W'(raw);
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/csfe_cmd_if.sv =====
interface csfe_cmd_if;
	import csfe_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [KIND_W-1:0]          kind;
	logic signed [COORD_W-1:0]  pos_x;
	logic signed [COORD_W-1:0]  pos_y;
	logic signed [COORD_W-1:0]  span_w;
	logic signed [COORD_W-1:0]  span_h;
	logic [WORD_W-1:0]          ants_age;
	logic [WORD_W-1:0]          color_a;
	logic [WORD_W-1:0]          color_b;

	modport source (
		output valid, kind, pos_x, pos_y, span_w, span_h, ants_age, color_a, color_b,
		input  ready
	);

	modport sink (
		input  valid, kind, pos_x, pos_y, span_w, span_h, ants_age, color_a, color_b,
		output ready
	);

endinterface

// ===== hw/rtl/csfe_rsp_if.sv =====
interface csfe_rsp_if;
	import csfe_pkg::*;

	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   read_pixel;
	logic [COUNT_W-1:0]  pixels_written;

	modport source (
		output valid, read_pixel, pixels_written,
		input  ready
	);

	modport sink (
		input  valid, read_pixel, pixels_written,
		output ready
	);

endinterface

// ===== hw/rtl/csfe_frame_store.sv =====
module csfe_frame_store (
	input  logic                    clk,
	input  logic                    we,
	input  logic                    re,
	input  logic [csfe_pkg::ADDR_W-1:0] addr,
	input  csfe_pkg::pixel_t        wdata,
	output csfe_pkg::pixel_t        rdata
);
	import csfe_pkg::*;

	pixel_t pixels_q [STORE_DEPTH];
	pixel_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			pixels_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= pixels_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/csfe_apb_regs.sv =====
module csfe_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [csfe_pkg::PADDR_W-1:0] paddr,
	input  logic [csfe_pkg::APB_W-1:0]   pwdata,
	output logic [csfe_pkg::APB_W-1:0]   prdata,
	output logic                         pready,
	output csfe_pkg::surface_t           surf
);
	import csfe_pkg::*;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             wr_en;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(WIDTH_MAX);
			height_q <= CFG_W'(HEIGHT_MAX);
		end else if (wr_en) begin
			if (reg_sel == REG_HEIGHT) begin
				height_q <= pwdata[CFG_W-1:0];
			end else begin
				width_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	assign prdata = (reg_sel == REG_HEIGHT) ? APB_W'(height_q) : APB_W'(width_q);

	assign surf.w = eff_dim(width_q, WIDTH_MAX);
	assign surf.h = eff_dim(height_q, HEIGHT_MAX);

endmodule

// ===== hw/rtl/clipped_span_fill_engine.sv =====
// Channel  Dir  Handshake      Payload
// cmd      in   valid/ready    kind, pos_x, pos_y, span_w, span_h, ants_age, color_a, color_b
// rsp      out  valid/ready    read_pixel, pixels_written
// apb      in   psel/penable   surface_width at 0x0, surface_height at 0x4
//
// After reset the frame store is swept to zero, one pixel a cycle, across all 4096 pixels; no
// command is taken until then, while register writes are taken at once.
// A line or rectangle passes through clip and base states into fill, which writes one pixel
// a cycle through the single store write port until the clipped pixels are all written.
// A set pixel passes through clip, base, limit and pixel states, a read pixel that lands on
// the surface also through a read wait, and a command that clips to nothing goes to done.
// The result sits in an output register; while it waits, the next command is worked on and
// then held in its last state, so a stalled rsp also holds off the command after it.
module clipped_span_fill_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	csfe_cmd_if.sink                     cmd,
	csfe_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [csfe_pkg::PADDR_W-1:0] paddr,
	input  logic [csfe_pkg::APB_W-1:0]   pwdata,
	output logic [csfe_pkg::APB_W-1:0]   prdata,
	output logic                         pready
);
	import csfe_pkg::*;

	localparam int SPAN_W = COORD_W + 2;
	localparam int MUL_A_W = COORD_W + 1;
	localparam int MUL_W = MUL_A_W + DIM_W + 1;
	localparam int LIM_W = COUNT_W;

	surface_t surf;

	state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic              out_valid_q;

	// Command registers
	logic [KIND_W-1:0]         kind_q;
	logic signed [COORD_W-1:0] x_q, y_q, w_q, h_q;
	logic [PHASE_W-1:0]        age_q;
	pixel_t                    ca_q, cb_q;

	// Clipped geometry and walk state
	logic [COL_W-1:0]   col0_q;
	logic [ROW_W-1:0]   row0_q;
	logic [DIM_W-1:0]   ncol_q, nrow_q;
	logic [DIM_W-1:0]   ci_q, ri_q;
	logic [ADDR_W-1:0]  fill_addr_q, row_addr_q;
	logic [PHASE_W-1:0] phase_q;
	logic signed [MUL_W-1:0] base_q;
	logic [LIM_W-1:0]   lim_q;
	logic [COUNT_W-1:0] count_q;
	logic [WORD_W-1:0]  rd_q;
	logic [WORD_W-1:0]  out_pixel_q;
	logic [COUNT_W-1:0] out_count_q;

	// Store port
	logic              st_we, st_re;
	logic [ADDR_W-1:0] st_addr;
	pixel_t            st_wdata, st_rdata;

	logic is_hline, is_vline, is_rect, is_ants, is_pix, is_fill;
	logic accept, out_load, last_col, last_row, pix_hit;

	// Clipping
	logic signed [SPAN_W-1:0] sx, sy, sxw, syh, sws, shs;
	logic signed [SPAN_W-1:0] sum_x, sum_y, x0, y0, wx_pre, hy_pre, wx, hy;
	logic okx, oky, xin, yin, go;

	// Shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [DIM_W:0]     mul_b;
	logic signed [MUL_W-1:0]   mul_p, addend, base_d;

	csfe_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.surf    (surf)
	);

	csfe_frame_store u_store (
		.clk   (clk),
		.we    (st_we),
		.re    (st_re),
		.addr  (st_addr),
		.wdata (st_wdata),
		.rdata (st_rdata)
	);

	assign is_hline = (kind_q == KIND_HLINE_SOLID) || (kind_q == KIND_HLINE_ANTS);
	assign is_vline = (kind_q == KIND_VLINE_SOLID) || (kind_q == KIND_VLINE_ANTS);
	assign is_rect  = (kind_q == KIND_RECT_SOLID);
	assign is_ants  = (kind_q == KIND_HLINE_ANTS) || (kind_q == KIND_VLINE_ANTS);
	assign is_pix   = (kind_q == KIND_SET_PIXEL) || (kind_q == KIND_READ_PIXEL);
	assign is_fill  = is_hline || is_vline || is_rect;

	assign accept   = (state_q == ST_IDLE) && cmd.valid;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// The far edge test uses start + span, which is the same sum whether or not
	// the start was pulled up to zero.
	always_comb begin
		sx    = SPAN_W'(x_q);
		sy    = SPAN_W'(y_q);
		sxw   = SPAN_W'(w_q);
		syh   = SPAN_W'(h_q);
		sws   = SPAN_W'(signed'({1'b0, surf.w}));
		shs   = SPAN_W'(signed'({1'b0, surf.h}));
		sum_x = sx + sxw;
		sum_y = sy + syh;
		x0     = (sx < 0) ? '0 : sx;
		y0     = (sy < 0) ? '0 : sy;
		wx_pre = (sx < 0) ? sum_x : sxw;
		hy_pre = (sy < 0) ? sum_y : syh;
		wx     = (sum_x > sws) ? (sws - x0) : wx_pre;
		hy     = (sum_y > shs) ? (shs - y0) : hy_pre;
		okx    = wx > 0;
		oky    = hy > 0;
		xin    = (sx >= 0) && (sx < sws);
		yin    = (sy >= 0) && (sy < shs);
		go     = (is_hline && okx && yin) || (is_vline && oky && xin) || (is_rect && okx && oky);
	end

	always_comb begin
		mul_b = signed'({1'b0, surf.w});
		if (state_q == ST_LIMIT) begin
			mul_a = MUL_A_W'(signed'({1'b0, surf.h}));
		end else if (is_pix) begin
			mul_a = MUL_A_W'(y_q);
		end else begin
			mul_a = MUL_A_W'(signed'({1'b0, row0_q}));
		end
		mul_p  = MUL_W'(mul_a) * MUL_W'(mul_b);
		addend = is_pix ? MUL_W'(x_q) : MUL_W'(signed'({1'b0, col0_q}));
		base_d = mul_p + addend;
	end

	assign last_col = (ci_q + DIM_W'(1)) == ncol_q;
	assign last_row = (ri_q + DIM_W'(1)) == nrow_q;
	assign pix_hit  = !base_q[MUL_W-1] && (base_q < MUL_W'(signed'({1'b0, lim_q})));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		st_we    = 1'b0;
		st_re    = 1'b0;
		st_addr  = fill_addr_q;
		st_wdata = ca_q;
		unique case (state_q)
			ST_CLEAR: begin
				st_we    = 1'b1;
				st_addr  = clr_q;
				st_wdata = '0;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_CLIP;
				end
			end
			ST_CLIP: begin
				if (is_pix || (is_fill && go)) begin
					state_d = ST_BASE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_BASE: begin
				state_d = is_pix ? ST_LIMIT : ST_FILL;
			end
			ST_LIMIT: begin
				state_d = ST_PIXEL;
			end
			ST_PIXEL: begin
				st_addr = base_q[ADDR_W-1:0];
				state_d = ST_DONE;
				if (pix_hit && (kind_q == KIND_SET_PIXEL)) begin
					st_we = 1'b1;
				end
				if (pix_hit && (kind_q == KIND_READ_PIXEL)) begin
					st_re   = 1'b1;
					state_d = ST_RDWAIT;
				end
			end
			ST_RDWAIT: begin
				state_d = ST_DONE;
			end
			ST_FILL: begin
				st_we = 1'b1;
				if (is_ants && !phase_q[ANTS_BIT]) begin
					st_wdata = cb_q;
				end
				if (last_col && last_row) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= cmd.kind;
			x_q     <= cmd.pos_x;
			y_q     <= cmd.pos_y;
			w_q     <= cmd.span_w;
			h_q     <= cmd.span_h;
			age_q   <= cmd.ants_age[PHASE_W-1:0];
			ca_q    <= PIXEL_BITS'(cmd.color_a);
			cb_q    <= PIXEL_BITS'(cmd.color_b);
			count_q <= '0;
			rd_q    <= '0;
		end
		case (state_q)
			ST_CLIP: begin
				// A vertical line keeps its column, a horizontal line its row.
				col0_q <= is_vline ? sx[COL_W-1:0] : x0[COL_W-1:0];
				row0_q <= is_hline ? sy[ROW_W-1:0] : y0[ROW_W-1:0];
				ncol_q <= is_vline ? DIM_W'(1) : wx[DIM_W-1:0];
				nrow_q <= is_hline ? DIM_W'(1) : hy[DIM_W-1:0];
			end
			ST_BASE: begin
				base_q      <= base_d;
				fill_addr_q <= base_d[ADDR_W-1:0];
				row_addr_q  <= base_d[ADDR_W-1:0];
				phase_q     <= age_q + PHASE_W'(row0_q) + PHASE_W'(col0_q);
				ci_q        <= '0;
				ri_q        <= '0;
			end
			ST_LIMIT: begin
				lim_q <= mul_p[LIM_W-1:0];
			end
			ST_PIXEL: begin
				if (pix_hit && (kind_q == KIND_SET_PIXEL)) begin
					count_q <= COUNT_W'(1);
				end
			end
			ST_RDWAIT: begin
				rd_q <= WORD_W'(st_rdata);
			end
			ST_FILL: begin
				count_q <= count_q + COUNT_W'(1);
				phase_q <= phase_q + PHASE_W'(1);
				if (last_col) begin
					ci_q        <= '0;
					ri_q        <= ri_q + DIM_W'(1);
					row_addr_q  <= row_addr_q + ADDR_W'(surf.w);
					fill_addr_q <= row_addr_q + ADDR_W'(surf.w);
				end else begin
					ci_q        <= ci_q + DIM_W'(1);
					fill_addr_q <= fill_addr_q + ADDR_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_pixel_q <= rd_q;
			out_count_q <= count_q;
		end
	end

	assign cmd.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.read_pixel     = out_pixel_q;
	assign rsp.pixels_written = out_count_q;

endmodule

// ===== test/fill_check_pkg.sv =====
package fill_check_pkg;
	import csfe_pkg::*;

	// Code 7 has no command behind it: nothing is written and both fields return zero.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

	typedef struct {
		logic [KIND_W-1:0]         kind;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] span_w;
		logic signed [COORD_W-1:0] span_h;
		logic [WORD_W-1:0]         ants_age;
		logic [WORD_W-1:0]         color_a;
		logic [WORD_W-1:0]         color_b;
	} fill_cmd_t;

	typedef struct {
		logic [WORD_W-1:0]  read_pixel;
		logic [COUNT_W-1:0] pixels_written;
	} fill_rsp_t;

	class fill_scoreboard;
		pixel_t           frame_copy [STORE_DEPTH];
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		fill_rsp_t        pending_results [$];
		int unsigned      errors;
		int unsigned      results_seen;
		int unsigned      kind_count [8];
		longint unsigned  pixels_painted;

		function new();
			foreach (frame_copy[i]) frame_copy[i] = '0;
			foreach (kind_count[i]) kind_count[i] = 0;
			width_reg      = CFG_W'(WIDTH_MAX);
			height_reg     = CFG_W'(HEIGHT_MAX);
			errors         = 0;
			results_seen   = 0;
			pixels_painted = 0;
		endfunction

		function void set_register(logic idx, logic [CFG_W-1:0] value);
			if (idx == REG_WIDTH)
				width_reg = value;
			else
				height_reg = value;
		endfunction

		function int eff_width();
			if (width_reg == '0)
				return 1;
			if (int'(width_reg) > WIDTH_MAX)
				return WIDTH_MAX;
			return int'(width_reg);
		endfunction

		function int eff_height();
			if (height_reg == '0)
				return 1;
			if (int'(height_reg) > HEIGHT_MAX)
				return HEIGHT_MAX;
			return int'(height_reg);
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		// Cuts [start, start + len) down to [0, lim); true when something is left.
		function bit clip(inout longint start, inout longint len, input longint lim);
			if (start < 0) begin
				len   = len + start;
				start = 0;
			end
			if (start + len > lim)
				len = lim - start;
			return len > 0;
		endfunction

		function pixel_t fill_colour(fill_cmd_t c, longint col, longint row);
			logic [WORD_W-1:0] phase;
			if (c.kind != KIND_HLINE_ANTS && c.kind != KIND_VLINE_ANTS)
				return pixel_t'(c.color_a);
			phase = c.ants_age + WORD_W'(row) + WORD_W'(col);
			return pixel_t'(phase[ANTS_BIT] ? c.color_a : c.color_b);
		endfunction

		function void paint(longint col, longint row, pixel_t value);
			frame_copy[row * eff_width() + col] = value;
		endfunction

		// Called once per command transfer: updates the frame copy and queues the result.
		function void note_command(fill_cmd_t c);
			longint            sw, sh, x, y, w, h;
			logic [WORD_W-1:0] lin, lim;
			fill_rsp_t         want;
			longint            count;
			sw = eff_width();
			sh = eff_height();
			x = c.pos_x;
			y = c.pos_y;
			w = c.span_w;
			h = c.span_h;
			want.read_pixel = '0;
			count = 0;
			kind_count[c.kind]++;
			case (c.kind)
				KIND_HLINE_SOLID, KIND_HLINE_ANTS: begin
					if (clip(x, w, sw) && y >= 0 && y < sh) begin
						for (longint k = 0; k < w; k++)
							paint(x + k, y, fill_colour(c, x + k, y));
						count = w;
					end
				end
				KIND_VLINE_SOLID, KIND_VLINE_ANTS: begin
					if (clip(y, h, sh) && x >= 0 && x < sw) begin
						for (longint k = 0; k < h; k++)
							paint(x, y + k, fill_colour(c, x, y + k));
						count = h;
					end
				end
				KIND_RECT_SOLID: begin
					// Both axes are clipped before either is judged.
					if (clip(x, w, sw) & clip(y, h, sh)) begin
						for (longint r = 0; r < h; r++)
							for (longint k = 0; k < w; k++)
								paint(x + k, y + r, pixel_t'(c.color_a));
						count = w * h;
					end
				end
				KIND_SET_PIXEL, KIND_READ_PIXEL: begin
					// Linear address taken modulo 2^32, so a negative column reaches
					// back into the previous row.
					lin = WORD_W'(x + y * sw);
					lim = WORD_W'(sw * sh);
					if (lin < lim && lin < STORE_DEPTH) begin
						if (c.kind == KIND_SET_PIXEL) begin
							frame_copy[lin] = pixel_t'(c.color_a);
							count = 1;
						end else begin
							want.read_pixel = WORD_W'(frame_copy[lin]);
						end
					end
				end
				default: ;
			endcase
			want.pixels_written = COUNT_W'(count);
			pixels_painted += count;
			pending_results.push_back(want);
		endfunction

		task report_mismatch(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			errors++;
			// Printing stops after a hundred so that a broken block does not flood the log.
			if (errors <= 100)
				$display("mismatch at %0t, result %0d, %s: expected %0h, got %0h",
					$time, results_seen, what, want, got);
		endtask

		task check_result(logic [WORD_W-1:0] pixel, logic [COUNT_W-1:0] written);
			fill_rsp_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no command outstanding", '0, pixel);
				return;
			end
			want = pending_results.pop_front();
			if (pixel !== want.read_pixel)
				report_mismatch("read_pixel", want.read_pixel, pixel);
			if (written !== want.pixels_written)
				report_mismatch("pixels_written", WORD_W'(want.pixels_written), WORD_W'(written));
		endtask
	endclass

endpackage

// ===== test/tb_top.sv =====
module tb_top;
	import csfe_pkg::*;
	import fill_check_pkg::*;

	// The clearing sweep after reset and a full-surface rectangle each write all 4096 pixels
	// with no transfer; this limit leaves ample room above both.
	localparam int STALL_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_W-1:0]   pwdata;
	logic [APB_W-1:0]   prdata;
	logic               pready;

	csfe_cmd_if cmd ();
	csfe_rsp_if rsp ();

	clipped_span_fill_engine dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	fill_scoreboard board;
	int             send_idle_pct;
	int             rsp_stall_pct;
	int             quiet_cycles;
	int             surfaces_set;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_result(rsp.read_pixel, rsp.pixels_written);
		rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("clipped_span_fill_engine test failed");
			$finish;
		end
	end

	// Writes a register, then reads it straight back.
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= {(APB_W-CFG_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_register(idx, value);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== value)
			board.report_mismatch("register read-back", WORD_W'(value), prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_surface(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		surfaces_set++;
	endtask

	task automatic send_cmd(input fill_cmd_t c);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid    <= 1'b1;
		cmd.kind     <= c.kind;
		cmd.pos_x    <= c.pos_x;
		cmd.pos_y    <= c.pos_y;
		cmd.span_w   <= c.span_w;
		cmd.span_h   <= c.span_h;
		cmd.ants_age <= c.ants_age;
		cmd.color_a  <= c.color_a;
		cmd.color_b  <= c.color_b;
		do @(posedge clk); while (!cmd.ready);
		board.note_command(c);
	endtask

	// Holds the command side off until every outstanding result has been returned.
	task automatic drain();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (board.outstanding() != 0);
	endtask

	function automatic fill_cmd_t make_command(logic [KIND_W-1:0] kind, int x, int y,
			int w, int h, logic [WORD_W-1:0] age, logic [WORD_W-1:0] ca,
			logic [WORD_W-1:0] cb);
		fill_cmd_t c;
		c.kind     = kind;
		c.pos_x    = COORD_W'(x);
		c.pos_y    = COORD_W'(y);
		c.span_w   = COORD_W'(w);
		c.span_h   = COORD_W'(h);
		c.ants_age = age;
		c.color_a  = ca;
		c.color_b  = cb;
		return c;
	endfunction

	// Mostly near the surface; now and then anywhere in the 16-bit range.
	function automatic logic [COORD_W-1:0] coord_near(int lim);
		if ($urandom_range(99) < 12)
			return COORD_W'($urandom);
		return COORD_W'(int'($urandom_range(lim + 16)) - 8);
	endfunction

	function automatic logic [COORD_W-1:0] span_value(int lim);
		int roll;
		roll = $urandom_range(99);
		if (roll < 12)
			return COORD_W'($urandom);
		if (roll < 18)
			return COORD_W'(lim + int'($urandom_range(8)));
		return COORD_W'(int'($urandom_range(18)) - 3);
	endfunction

	function automatic fill_cmd_t random_command();
		fill_cmd_t c;
		int        roll;
		roll = $urandom_range(99);
		if (roll < 15) begin
			c.kind = KIND_READ_PIXEL;
		end else if (roll < 27) begin
			c.kind = KIND_SET_PIXEL;
		end else if (roll < 29) begin
			c.kind = KIND_UNUSED;
		end else begin
			case ($urandom_range(4))
				0: c.kind = KIND_HLINE_SOLID;
				1: c.kind = KIND_VLINE_SOLID;
				2: c.kind = KIND_RECT_SOLID;
				3: c.kind = KIND_HLINE_ANTS;
				default: c.kind = KIND_VLINE_ANTS;
			endcase
		end
		c.pos_x    = coord_near(board.eff_width());
		c.pos_y    = coord_near(board.eff_height());
		c.span_w   = span_value(board.eff_width());
		c.span_h   = span_value(board.eff_height());
		c.ants_age = $urandom;
		c.color_a  = $urandom;
		c.color_b  = $urandom;
		return c;
	endfunction

	task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				drain();
			send_cmd(random_command());
		end
		drain();
	endtask

	initial begin
		fill_cmd_t opening [$];
		board         = new();
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		cmd.valid     = 1'b0;
		cmd.kind      = '0;
		cmd.pos_x     = '0;
		cmd.pos_y     = '0;
		cmd.span_w    = '0;
		cmd.span_h    = '0;
		cmd.ants_age  = '0;
		cmd.color_a   = '0;
		cmd.color_b   = '0;
		rsp.ready     = 1'b0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		quiet_cycles  = 0;
		surfaces_set  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Edge and clipping cases on the reset surface of 64 by 64.
		opening.push_back(make_command(KIND_READ_PIXEL, 0, 0, 0, 0, 0, 0, 0));
		opening.push_back(make_command(KIND_HLINE_SOLID, -5, 3, 20, 0, 0, 32'h1111_2222, 0));
		opening.push_back(make_command(KIND_HLINE_SOLID, 50, 4, 30, 0, 0, 32'h3333_4444, 0));
		opening.push_back(make_command(KIND_HLINE_SOLID, 0, 64, 10, 0, 0, 32'h5, 0));
		opening.push_back(make_command(KIND_HLINE_SOLID, 0, -1, 10, 0, 0, 32'h6, 0));
		opening.push_back(make_command(KIND_HLINE_SOLID, 10, 10, 0, 0, 0, 32'h7, 0));
		opening.push_back(make_command(KIND_HLINE_SOLID, 10, 10, -5, 0, 0, 32'h8, 0));
		opening.push_back(make_command(KIND_VLINE_SOLID, 7, -3, 0, 10, 0, 32'h9999_0000, 0));
		opening.push_back(make_command(KIND_VLINE_SOLID, -1, 0, 0, 10, 0, 32'ha, 0));
		opening.push_back(make_command(KIND_VLINE_SOLID, 63, 60, 0, 100, 0, 32'hb, 0));
		opening.push_back(make_command(KIND_RECT_SOLID, -10, -10, 200, 200, 0, '1, 0));
		opening.push_back(make_command(KIND_RECT_SOLID, 5, 5, 0, 9, 0, 32'hc, 0));
		opening.push_back(make_command(KIND_RECT_SOLID, 32767, 0, 32767, 5, 0, 32'hd, 0));
		opening.push_back(make_command(KIND_RECT_SOLID, -32768, -32768, 32767, 32767,
			0, 32'he, 0));
		opening.push_back(make_command(KIND_HLINE_ANTS, -3, 20, 70, 0, '1,
			32'hdead_beef, 32'h0bad_f00d));
		opening.push_back(make_command(KIND_VLINE_ANTS, 40, -2, 0, 80, 32'hffff_fffa,
			32'hcafe_0001, 32'h0000_cafe));
		opening.push_back(make_command(KIND_RECT_SOLID, 2, 3, 6, 4, 0, 32'h0, 0));
		opening.push_back(make_command(KIND_SET_PIXEL, 63, 63, 0, 0, 0, 32'ha5a5_5a5a, 0));
		opening.push_back(make_command(KIND_READ_PIXEL, 63, 63, 0, 0, 0, 0, 0));
		opening.push_back(make_command(KIND_SET_PIXEL, -1, 1, 0, 0, 0, 32'h1234_5678, 0));
		opening.push_back(make_command(KIND_READ_PIXEL, 63, 0, 0, 0, 0, 0, 0));
		opening.push_back(make_command(KIND_SET_PIXEL, 0, 64, 0, 0, 0, 32'h7777_7777, 0));
		opening.push_back(make_command(KIND_READ_PIXEL, -1, 0, 0, 0, 0, 0, 0));
		opening.push_back(make_command(KIND_READ_PIXEL, 32767, -32768, 0, 0, 0, 0, 0));
		opening.push_back(make_command(KIND_UNUSED, -1, -1, -1, -1, '1, '1, '1));
		foreach (opening[i])
			send_cmd(opening[i]);
		drain();

		set_surface(7'd64, 7'd64);
		run_phase(400, 0, 0);
		set_surface(7'd20, 7'd12);
		run_phase(250, 77, 0);
		// Zero registers act as a one-by-one surface.
		set_surface(7'd0, 7'd0);
		run_phase(150, 0, 77);
		// Values past the maximum act as the maximum.
		set_surface(7'd127, 7'd100);
		run_phase(250, 12, 12);
		set_surface(7'd1, 7'd64);
		run_phase(150, 0, 0);
		set_surface(7'd64, 7'd1);
		run_phase(150, 77, 0);
		set_surface(7'd37, 7'd45);
		run_phase(250, 0, 77);
		set_surface(7'd8, 7'd5);
		run_phase(150, 12, 12);

		repeat (20) @(posedge clk);
		$display("Sent %0d fills (%0d ants), %0d pixel sets, %0d reads and %0d unused codes",
			board.kind_count[KIND_HLINE_SOLID] + board.kind_count[KIND_VLINE_SOLID]
				+ board.kind_count[KIND_RECT_SOLID] + board.kind_count[KIND_HLINE_ANTS]
				+ board.kind_count[KIND_VLINE_ANTS],
			board.kind_count[KIND_HLINE_ANTS] + board.kind_count[KIND_VLINE_ANTS],
			board.kind_count[KIND_SET_PIXEL], board.kind_count[KIND_READ_PIXEL],
			board.kind_count[KIND_UNUSED]);
		$display("over %0d surface settings; %0d pixels painted, %0d results checked, %0d errors",
			surfaces_set, board.pixels_painted, board.results_seen, board.errors);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("clipped_span_fill_engine test passed");
		else
			$display("clipped_span_fill_engine test failed");
		$finish;
	end

endmodule

// ===== clipped_span_fill_engine.f =====
hw/rtl/csfe_pkg.sv
hw/rtl/csfe_cmd_if.sv
hw/rtl/csfe_rsp_if.sv
hw/rtl/csfe_frame_store.sv
hw/rtl/csfe_apb_regs.sv
hw/rtl/clipped_span_fill_engine.sv
test/fill_check_pkg.sv
test/tb_top.sv
